[src/mfh_pkg.sv]
package mfh_pkg;

   // FNV-64 constants; the prime is 2^40 + 0x1b3
   localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME       = 64'h00000100000001b3;
   localparam logic [63:0] FNV_PRIME_LOW   = 64'h00000000000001b3;
   localparam int          FNV_PRIME_SHIFT = 40;

   // fmix64 finalizer constants
   localparam logic [63:0] MIX_K1    = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_K2    = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT = 33;

   // byte placement stride inside a word
   localparam logic [2:0]  BYTE_STRIDE = 3'd7;

   // hash state geometry: two banks of four words
   localparam int NUM_WORDS  = 8;
   localparam int BANK_DEPTH = 4;

   typedef enum logic {
      FUNC_ABSORB = 1'b0,
      FUNC_FINISH = 1'b1
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // handshake between the sequencer and the finalizer
   typedef struct packed {
      logic        start;
      logic [63:0] value;
   } mix_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } mix_stat_type;

endpackage

[src/mfh_ram.sv]
module mfh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mfh_fmix.sv]
module mfh_fmix import mfh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mix_cmd_type  cmd,
   output mix_stat_type stat
);

   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  phase_ff, phase_in;
   logic        mul_sel_ff, mul_sel_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [63:0] kc;
   logic [31:0] op_a, op_b;
   logic [63:0] prod, addend, sum;

   // operand select for one 32x32 partial product per cycle
   always_comb begin
      kc = mul_sel_ff ? MIX_K2 : MIX_K1;
      case (phase_ff)
         2'd0: begin
            op_a = x_ff[31:0];
            op_b = kc[31:0];
         end
         2'd1: begin
            op_a = x_ff[31:0];
            op_b = kc[63:32];
         end
         default: begin
            op_a = x_ff[63:32];
            op_b = kc[31:0];
         end
      endcase
      prod   = 64'(op_a) * 64'(op_b);
      addend = (phase_ff == 2'd0) ? prod : {prod[31:0], 32'd0};
      sum    = ((phase_ff == 2'd0) ? 64'd0 : acc_ff) + addend;
   end

   // sequencer: xorshift at load, two multiplies of three steps each
   always_comb begin
      x_in       = x_ff;
      acc_in     = acc_ff;
      phase_in   = phase_ff;
      mul_sel_in = mul_sel_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         x_in       = cmd.value ^ (cmd.value >> MIX_SHIFT);
         acc_in     = 64'd0;
         phase_in   = 2'd0;
         mul_sel_in = 1'b0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum;
         if (phase_ff == 2'd2) begin
            // product complete: fold the high bits back in
            x_in     = sum ^ (sum >> MIX_SHIFT);
            phase_in = 2'd0;
            if (mul_sel_ff) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               mul_sel_in = 1'b1;
            end
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         phase_ff   <= 2'd0;
         mul_sel_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         phase_ff   <= phase_in;
         mul_sel_ff <= mul_sel_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = x_ff;

endmodule

[src/multiword_fnv_byte_hash_top.sv]
// Channel  Ports                          Word                 Direction
// -------  -----------------------------  -------------------  ---------
// request  req_valid req_ready req_data   req_type (func,byte) in
// result   rsp_valid rsp_ready rsp_data   rsp_type (digest)    out
//
// An absorb word is a read of the target hash word from its bank, then the
// xor and prime multiply with write-back. A finish word takes, per digest
// word, a read, a load, six finalizer steps on the shared 32x32 multiplier,
// a done cycle and the output, which waits while rsp is stalled.
// Reset is synchronous: eight valid bits mark the hash words as holding their
// initial values. rsp_ready low holds the digest word in the output register
// and stalls the finish sequence before it outputs its next word.
module multiword_fnv_byte_hash_top import mfh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(BANK_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ABSORB = 6'b000010,
      ST_FREAD  = 6'b000100,
      ST_FLOAD  = 6'b001000,
      ST_FMIX   = 6'b010000,
      ST_FOUT   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [5:0]           pos_ff, pos_in;
   logic [1:0]           k_ff, k_in;
   logic [NUM_WORDS-1:0] valid_ff, valid_in;
   logic [63:0]          shifted_ff, shifted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [63:0]   q_lo, q_hi;
   logic [63:0]   word_lo, word_hi;
   logic [AW-1:0] sel_addr;
   logic [63:0]   cur_word, mixed, absorbed;
   logic          wr_lo, wr_hi;
   logic [5:0]    shift_amt;
   logic          req_fire, out_free;

   mix_cmd_type  mix_cmd;
   mix_stat_type mix_stat;

   // initial value of a hash word: odd words hold the prime
   function automatic logic [63:0] word_reset(input logic odd);
      return odd ? FNV_PRIME : FNV_BASIS;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // both banks read at the same address: byte position or digest index
   assign rd_en   = (state_ff == ST_IDLE) || (state_ff == ST_FREAD);
   assign rd_addr = (state_ff == ST_FREAD) ? k_ff : pos_ff[AW-1:0];

   mfh_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_bank_lo (
      .clock   (clock),
      .wr_en   (wr_lo),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (absorbed),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (q_lo)
   );

   mfh_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_bank_hi (
      .clock   (clock),
      .wr_en   (wr_hi),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (absorbed),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (q_hi)
   );

   mfh_fmix u_fmix (
      .clock (clock),
      .reset (reset),
      .cmd   (mix_cmd),
      .stat  (mix_stat)
   );

   // read data, replaced by the initial value where a word was never written
   always_comb begin
      sel_addr = (state_ff == ST_FLOAD) ? k_ff : pos_ff[AW-1:0];
      word_lo  = valid_ff[{1'b0, sel_addr}] ? q_lo : word_reset(sel_addr[0]);
      word_hi  = valid_ff[{1'b1, sel_addr}] ? q_hi : word_reset(sel_addr[0]);
      cur_word = pos_ff[AW] ? word_hi : word_lo;
   end

   // absorb: xor in the placed byte, multiply by 2^40 + 0x1b3
   always_comb begin
      mixed    = cur_word ^ shifted_ff;
      absorbed = (mixed << FNV_PRIME_SHIFT) + mixed * FNV_PRIME_LOW;
      wr_lo    = (state_ff == ST_ABSORB) && !pos_ff[AW];
      wr_hi    = (state_ff == ST_ABSORB) && pos_ff[AW];
   end

   // byte placement: shift by 7n mod 64
   assign shift_amt  = 6'(pos_ff * BYTE_STRIDE);
   assign shifted_in = 64'(req_data.data_byte) << shift_amt;

   assign mix_cmd.start = (state_ff == ST_FLOAD);
   assign mix_cmd.value = word_lo ^ word_hi;

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.func == FUNC_FINISH) begin
                  k_in     = 2'd0;
                  state_in = ST_FREAD;
               end else begin
                  state_in = ST_ABSORB;
               end
            end
         end
         ST_ABSORB: begin
            valid_in[pos_ff[2:0]] = 1'b1;
            pos_in   = pos_ff + 6'd1;
            state_in = ST_IDLE;
         end
         ST_FREAD: begin
            state_in = ST_FLOAD;
         end
         ST_FLOAD: begin
            state_in = ST_FMIX;
         end
         ST_FMIX: begin
            if (mix_stat.done) begin
               state_in = ST_FOUT;
            end
         end
         ST_FOUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.digest_word = mix_stat.result;
               rsp_in.word_index  = k_ff;
               rsp_in.last_word   = (k_ff == 2'd3);
               if (k_ff == 2'd3) begin
                  // restart for the next message
                  valid_in = '0;
                  pos_in   = 6'd0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_FREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= 6'd0;
         k_ff         <= 2'd0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (req_fire) begin
         shifted_ff <= shifted_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[tb/fnv_digest_checker.sv]
module fnv_digest_checker import mfh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      words_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // predicted hash state
   logic [63:0] hash_word [NUM_WORDS];
   logic [5:0]  byte_pos;

   // digest words still owed by the block, oldest first
   rsp_type     digest_queue [$];
   int          fails = 0;

   // even words start at the offset basis, odd words at the prime
   function automatic void restart_hash();
      for (int i = 0; i < NUM_WORDS; i++) begin
         hash_word[i] = i[0] ? FNV_PRIME : FNV_BASIS;
      end
      byte_pos = '0;
   endfunction

   always @(posedge clock) begin : predict_and_check
      logic [2:0]  sel;
      logic [5:0]  sh;
      logic [63:0] mix;
      rsp_type     want;

      if (reset) begin
         restart_hash();
         digest_queue.delete();
      end else begin
         // request side: absorb a byte or fold and finalize
         if (req_valid && req_ready) begin
            if (req_data.func == FUNC_ABSORB) begin
               sel = byte_pos[2:0];
               sh  = 6'(byte_pos * 7);
               hash_word[sel] = (hash_word[sel] ^ (64'(req_data.data_byte) << sh))
                                * FNV_PRIME;
               byte_pos = byte_pos + 6'd1;
            end else begin
               for (int k = 0; k < 4; k++) begin
                  mix = hash_word[k] ^ hash_word[k + 4];
                  mix = mix ^ (mix >> MIX_SHIFT);
                  mix = mix * MIX_K1;
                  mix = mix ^ (mix >> MIX_SHIFT);
                  mix = mix * MIX_K2;
                  mix = mix ^ (mix >> MIX_SHIFT);
                  want.digest_word = mix;
                  want.word_index  = 2'(k);
                  want.last_word   = (k == 3);
                  digest_queue.push_back(want);
               end
               restart_hash();
            end
         end

         // result side: compare against the oldest expected word
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest word %h (index %0d)",
                      rsp_data.digest_word, rsp_data.word_index);
               fails++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want.digest_word, rsp_data.digest_word);
                  fails++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, actual %0d",
                         want.word_index, rsp_data.word_index);
                  fails++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %0b, actual %0b",
                         want.last_word, rsp_data.last_word);
                  fails++;
               end
            end
         end
      end

      mismatch_count <= fails;
      words_owed     <= digest_queue.size();
   end

endmodule

[tb/multiword_fnv_byte_hash_top_tb.sv]
module multiword_fnv_byte_hash_top_tb;
   import mfh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      mismatch_count;
   int      words_owed;
   bit      idle_en    = 1'b0;
   int      words_sent = 0;

   multiword_fnv_byte_hash_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fnv_digest_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .words_owed     (words_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_en && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // present one request word and hold it until accepted
   task automatic send_word(input func_type f, input logic [7:0] d);
      req_type w;
      w.func      = f;
      w.data_byte = d;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   initial begin : stimulus
      int   msg_len;
      bit   long_done;
      logic [7:0] edge_bytes [10];

      edge_bytes = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f,
                     8'haa, 8'h55, 8'hfe, 8'hff, 8'hff};
      long_done  = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, then finish again with a junk byte
      idle_en = 1'b1;
      send_word(FUNC_FINISH, 8'h00);
      send_word(FUNC_FINISH, 8'hff);

      // extreme bytes across all eight words; position 9 shifts
      // bits out past bit 63
      foreach (edge_bytes[i]) send_word(FUNC_ABSORB, edge_bytes[i]);
      send_word(FUNC_FINISH, 8'h5a);

      // single byte message right after a restart
      send_word(FUNC_ABSORB, 8'hff);
      send_word(FUNC_FINISH, 8'h00);

      // random messages; the first one reaches or runs past the position wrap
      while (words_sent < 160) begin
         idle_en = (words_sent < 125) && ($urandom_range(0, 2) != 0);
         // long messages only early, so the total stays near the target
         if (!long_done || ($urandom_range(0, 9) == 0 && words_sent < 80)) begin
            msg_len = $urandom_range(64, 72);
         end else begin
            msg_len = $urandom_range(0, 12);
         end
         long_done = 1'b1;
         repeat (msg_len) send_word(FUNC_ABSORB, 8'($urandom_range(0, 255)));
         send_word(FUNC_FINISH, 8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      // drain outstanding digest words, then let the pipeline settle
      do @(posedge clock); while (words_owed != 0);
      repeat (50) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
src/mfh_pkg.sv
src/mfh_ram.sv
src/mfh_fmix.sv
src/multiword_fnv_byte_hash_top.sv
tb/fnv_digest_checker.sv
tb/multiword_fnv_byte_hash_top_tb.sv
